// ----- hdl/lmbs_pkg.sv -----
// Shared types and constants for the LED matrix blink scanner.
package lmbs_pkg;

    // Default matrix geometry.
    localparam int DEFAULT_ROWS    = 11;
    localparam int DEFAULT_COLUMNS = 6;

    // Fixed field widths of the command and result transfers.
    localparam int FUNC_W      = 3;
    localparam int LED_INDEX_W = 7;
    localparam int COLUMN_W    = 3;
    localparam int ROW_BITS_W  = 11;

    // Configuration register file.
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam int HALF_W     = 8;
    localparam logic [APB_ADDR_W-1:0] REG_BLINK_HALF_PERIOD = 2'd0;
    localparam logic [HALF_W-1:0]     HALF_PERIOD_RESET     = 8'd250;

    // Command codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LIGHT  = 3'd0,
        FUNC_FLASH  = 3'd1,
        FUNC_CLOSE  = 3'd2,
        FUNC_TOGGLE = 3'd3,
        FUNC_TICK   = 3'd4,
        FUNC_SCAN   = 3'd5
    } t_func;

    // Per-LED update request sent to the flag store.
    typedef struct packed {
        logic                   en;
        logic [FUNC_W-1:0]      func;
        logic [LED_INDEX_W-1:0] led_index;
    } t_flag_cmd;

endpackage

// ----- hdl/lmbs_flag_store.sv -----
// On and blink flags for every LED, with the per-LED updates and the column scan.
module lmbs_flag_store import lmbs_pkg::*; #(
    parameter int ROWS    = DEFAULT_ROWS,
    parameter int COLUMNS = DEFAULT_COLUMNS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_flag_cmd             i_cmd,
    input  logic                  i_blink_phase,
    input  logic [COLUMN_W-1:0]   i_scan_column,
    output logic [ROW_BITS_W-1:0] o_row_bits
);

    localparam int LED_TOTAL = ROWS * COLUMNS;
    localparam int OUT_ROWS  = (ROWS < ROW_BITS_W) ? ROWS : ROW_BITS_W;

    logic [LED_TOTAL-1:0] r_lit;
    logic [LED_TOTAL-1:0] r_blink;
    logic [LED_TOTAL-1:0] n_lit;
    logic [LED_TOTAL-1:0] n_blink;
    logic [LED_TOTAL-1:0] drive;

    // Decode the command against every LED; an index past the matrix hits none.
    always_comb begin
        n_lit   = r_lit;
        n_blink = r_blink;
        for (int n = 0; n < LED_TOTAL; n++) begin
            if (i_cmd.en && (32'(i_cmd.led_index) == n)) begin
                case (i_cmd.func)
                    FUNC_LIGHT: begin
                        n_lit[n]   = 1'b1;
                        n_blink[n] = 1'b0;
                    end
                    FUNC_FLASH: begin
                        n_lit[n]   = 1'b1;
                        n_blink[n] = 1'b1;
                    end
                    FUNC_CLOSE: begin
                        n_lit[n]   = 1'b0;
                        n_blink[n] = 1'b0;
                    end
                    FUNC_TOGGLE: begin
                        n_lit[n] = ~r_lit[n];
                    end
                    default: begin
                        n_lit[n]   = r_lit[n];
                        n_blink[n] = r_blink[n];
                    end
                endcase
            end
        end
    end

    // Flag registers, all cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit   <= '0;
            r_blink <= '0;
        end else begin
            r_lit   <= n_lit;
            r_blink <= n_blink;
        end
    end

    // An LED drives when it is on and either steady or in the lit phase.
    assign drive = r_lit & (~r_blink | {LED_TOTAL{i_blink_phase}});

    // Select the scanned column in every row; a column past the matrix reads zero.
    always_comb begin
        o_row_bits = '0;
        for (int r = 0; r < OUT_ROWS; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
                if (32'(i_scan_column) == c) begin
                    o_row_bits[r] = drive[r * COLUMNS + c];
                end
            end
        end
    end

endmodule

// ----- hdl/led_matrix_blink_scanner.sv -----
// Top level of the LED matrix blink scanner: command stage, blink timer, result register.
//
//  channel   direction  handshake                      payload
//  command   in         i_in_valid / o_in_ready        i_func, i_led_index, i_column
//  result    out        o_out_valid / i_out_ready      o_row_bits
//  config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One command is taken every cycle while no scan waits in the command register. A
// scan result is registered in the command register and then in the result register.
// Commands other than scan leave the command register in the next cycle even
// when the result register is full. A scan waits in the command register while
// the result register holds an untaken result. Reset is synchronous and clears
// flags, the blink timer and both valid bits.
module led_matrix_blink_scanner import lmbs_pkg::*; #(
    parameter int ROWS    = DEFAULT_ROWS,
    parameter int COLUMNS = DEFAULT_COLUMNS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [LED_INDEX_W-1:0]  i_led_index,
    input  logic [COLUMN_W-1:0]     i_column,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [ROW_BITS_W-1:0]   o_row_bits,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    logic                   r_s1_valid;
    logic [FUNC_W-1:0]      r_s1_func;
    logic [LED_INDEX_W-1:0] r_s1_led_index;
    logic [COLUMN_W-1:0]    r_s1_column;
    logic                   r_out_valid;
    logic [ROW_BITS_W-1:0]  r_out_row_bits;
    logic [HALF_W-1:0]      r_half_period;
    logic [HALF_W-1:0]      r_tick_count;
    logic [HALF_W-1:0]      n_tick_count;
    logic                   r_blink_phase;
    logic                   n_blink_phase;
    logic                   s1_is_scan;
    logic                   s1_is_led;
    logic                   s1_fire;
    logic                   out_free;
    t_flag_cmd              flag_cmd;
    logic [ROW_BITS_W-1:0]  scan_bits;

    // Configuration register: written on the access phase of an APB write.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
        end else if (psel && penable && pwrite && (paddr == REG_BLINK_HALF_PERIOD)) begin
            r_half_period <= pwdata[HALF_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_BLINK_HALF_PERIOD) begin
            prdata = {{(APB_DATA_W-HALF_W){1'b0}}, r_half_period};
        end
    end

    // Command stage flow control: only a scan needs room in the result register.
    always_comb begin
        s1_is_scan = (r_s1_func == FUNC_SCAN);
        s1_is_led  = r_s1_func inside {FUNC_LIGHT, FUNC_FLASH, FUNC_CLOSE, FUNC_TOGGLE};
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && (!s1_is_scan || out_free);
    assign o_in_ready = !r_s1_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_func      <= i_func;
            r_s1_led_index <= i_led_index;
            r_s1_column    <= i_column;
        end
    end

    // Blink timer: the phase inverts once the count reaches the half-period.
    always_comb begin
        n_tick_count  = r_tick_count;
        n_blink_phase = r_blink_phase;
        if (s1_fire && (r_s1_func == FUNC_TICK)) begin
            n_tick_count = r_tick_count + 8'd1;
            if (n_tick_count >= r_half_period) begin
                n_tick_count  = '0;
                n_blink_phase = ~r_blink_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count  <= '0;
            r_blink_phase <= 1'b0;
        end else begin
            r_tick_count  <= n_tick_count;
            r_blink_phase <= n_blink_phase;
        end
    end

    // Flag storage and column scan.
    assign flag_cmd.en        = s1_fire && s1_is_led;
    assign flag_cmd.func      = r_s1_func;
    assign flag_cmd.led_index = r_s1_led_index;

    lmbs_flag_store #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_flag_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (flag_cmd),
        .i_blink_phase (r_blink_phase),
        .i_scan_column (r_s1_column),
        .o_row_bits    (scan_bits)
    );

    // Result register: loaded by a scan, emptied by an output transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && s1_is_scan) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_is_scan) begin
            r_out_row_bits <= scan_bits;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_row_bits  = r_out_row_bits;

endmodule

// ----- hdl/lmbs_checker.sv -----
// Port-level checks for the LED matrix blink scanner, bound to the top level.
module lmbs_checker import lmbs_pkg::*; #(
    parameter int COLUMNS = DEFAULT_COLUMNS
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic [FUNC_W-1:0]      i_func,
    input logic [COLUMN_W-1:0]    i_column,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [ROW_BITS_W-1:0]  o_row_bits
);

    // Reset empties both stages.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    // A new result comes only from an earlier scan transfer.
    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && (i_func == FUNC_SCAN), 2))
        else $error("result without a matching scan transfer");

    // A scan of a column past the matrix drives no rows.
    a_off_column_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && (32'($past(i_column, 2)) >= COLUMNS) |-> (o_row_bits == '0))
        else $error("off-matrix column drove rows");

    // A stalled result holds its value.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_row_bits))
        else $error("stalled result changed");

endmodule

bind led_matrix_blink_scanner lmbs_checker #(
    .COLUMNS (COLUMNS)
) u_lmbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_func      (i_func),
    .i_column    (i_column),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_row_bits  (o_row_bits)
);

// ----- bench/led_matrix_blink_scanner_tb.sv -----
// Self-checking testbench for the LED matrix blink scanner with a flag and blink-timer predictor.
`timescale 1ns / 1ps

module led_matrix_blink_scanner_tb;
    import lmbs_pkg::*;

    localparam int LED_COUNT = DEFAULT_ROWS * DEFAULT_COLUMNS;
    localparam int SETTLE_CYCLES = 6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0]      func;
        logic [LED_INDEX_W-1:0] led_index;
        logic [COLUMN_W-1:0]    column;
    } t_cmd;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [FUNC_W-1:0]      i_func = '0;
    logic [LED_INDEX_W-1:0] i_led_index = '0;
    logic [COLUMN_W-1:0]    i_column = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [ROW_BITS_W-1:0]  o_row_bits;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = REG_BLINK_HALF_PERIOD;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Predicted block state.
    bit                     lit_model [LED_COUNT];
    bit                     blink_model [LED_COUNT];
    logic [HALF_W-1:0]      tick_model = '0;
    bit                     phase_model = 1'b0;
    logic [HALF_W-1:0]      half_model = HALF_PERIOD_RESET;

    t_cmd                   pending_cmds [$];
    logic [ROW_BITS_W-1:0]  expected_rows [$];
    int                     errors = 0;
    int                     send_gap = 0;
    int                     recv_stall = 0;
    bit                     send_idle = 1'b1;
    bit                     recv_idle = 1'b1;

    led_matrix_blink_scanner uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_led_index (i_led_index),
        .i_column    (i_column),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_row_bits  (o_row_bits),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 i_clk = ~i_clk;

    // Row drive bits of one column under the predicted flags and blink phase.
    function automatic logic [ROW_BITS_W-1:0] scan_rows(input logic [COLUMN_W-1:0] col);
        logic [ROW_BITS_W-1:0] rows;
        int n;
        rows = '0;
        if (col < DEFAULT_COLUMNS) begin
            for (int r = 0; r < DEFAULT_ROWS && r < ROW_BITS_W; r++) begin
                n = r * DEFAULT_COLUMNS + col;
                if (lit_model[n] && (!blink_model[n] || phase_model))
                    rows[r] = 1'b1;
            end
        end
        return rows;
    endfunction

    // Apply one accepted command to the predicted state.
    task automatic apply_command(input t_cmd c);
        case (c.func)
            FUNC_LIGHT, FUNC_FLASH, FUNC_CLOSE, FUNC_TOGGLE: begin
                if (c.led_index < LED_COUNT) begin
                    case (c.func)
                        FUNC_LIGHT: begin
                            lit_model[c.led_index] = 1'b1;
                            blink_model[c.led_index] = 1'b0;
                        end
                        FUNC_FLASH: begin
                            lit_model[c.led_index] = 1'b1;
                            blink_model[c.led_index] = 1'b1;
                        end
                        FUNC_CLOSE: begin
                            lit_model[c.led_index] = 1'b0;
                            blink_model[c.led_index] = 1'b0;
                        end
                        default: lit_model[c.led_index] = ~lit_model[c.led_index];
                    endcase
                end
            end
            FUNC_TICK: begin
                tick_model = tick_model + 1'b1;
                if (tick_model >= half_model) begin
                    tick_model = '0;
                    phase_model = ~phase_model;
                end
            end
            FUNC_SCAN: expected_rows.push_back(scan_rows(c.column));
            default: ;
        endcase
    endtask

    // Command driver: holds each item until its transfer, then waits a drawn gap.
    always @(posedge i_clk) begin
        t_cmd c;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_in_valid && o_in_ready)
                apply_command('{i_func, i_led_index, i_column});
            if (i_in_valid && !o_in_ready) begin
                // Hold the current item.
            end else if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                i_in_valid <= 1'b1;
                i_func <= c.func;
                i_led_index <= c.led_index;
                i_column <= c.column;
                send_gap <= send_idle ? $urandom_range(0, 6) : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each transfer and stalls ready for a drawn count.
    always @(posedge i_clk) begin
        int wait_cycles;
        logic [ROW_BITS_W-1:0] want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            wait_cycles = recv_stall;
            if (o_out_valid && i_out_ready) begin
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual row_bits %h",
                             $time, o_row_bits);
                    errors++;
                end else begin
                    want = expected_rows.pop_front();
                    if (o_row_bits !== want) begin
                        $display("%0t: row_bits mismatch, expected %h, actual %h",
                                 $time, want, o_row_bits);
                        errors++;
                    end
                end
                wait_cycles = recv_idle ? $urandom_range(0, 6) : 0;
            end
            if (wait_cycles > 0) begin
                i_out_ready <= 1'b0;
                recv_stall <= wait_cycles - 1;
            end else begin
                i_out_ready <= 1'b1;
                recv_stall <= 0;
            end
        end
    end

    // Write the half-period register and read it back.
    task automatic write_half_period(input logic [HALF_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_BLINK_HALF_PERIOD;
        pwdata <= {{(APB_DATA_W-HALF_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        half_model = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[HALF_W-1:0] !== value) begin
            $display("%0t: half-period readback mismatch, expected %h, actual %h",
                     $time, value, prdata[HALF_W-1:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every queued command is sent and every scan result has come back.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || i_in_valid || expected_rows.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_cmd(input logic [FUNC_W-1:0] f, input int idx, input int col);
        pending_cmds.push_back('{f, idx[LED_INDEX_W-1:0], col[COLUMN_W-1:0]});
    endtask

    // Random command mix: mostly in-range LED updates, ticks and valid scans.
    task automatic push_random(input int count, input int tick_pct);
        int r;
        int idx;
        int col;
        logic [FUNC_W-1:0] f;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            idx = $urandom_range(0, 127);
            col = $urandom_range(0, 7);
            if (r < tick_pct) begin
                f = FUNC_TICK;
            end else if (r < tick_pct + 25) begin
                f = FUNC_SCAN;
                col = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(6, 7);
            end else if (r < 97) begin
                f = FUNC_W'($urandom_range(0, 3));
                if ($urandom_range(0, 9) != 0)
                    idx = $urandom_range(0, LED_COUNT - 1);
            end else begin
                f = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
            end
            pending_cmds.push_back('{f, idx[LED_INDEX_W-1:0], col[COLUMN_W-1:0]});
        end
    endtask

    // Overall run limit.
    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed commands under the reset half-period.
        push_cmd(FUNC_SCAN, 0, 0);
        push_cmd(FUNC_LIGHT, 0, 7);
        push_cmd(FUNC_FLASH, LED_COUNT - 1, 0);
        push_cmd(FUNC_TOGGLE, 1, 0);
        push_cmd(FUNC_TOGGLE, 0, 0);
        push_cmd(FUNC_LIGHT, 6, 0);
        push_cmd(FUNC_FLASH, 60, 0);
        push_cmd(FUNC_LIGHT, 127, 0);
        push_cmd(FUNC_FLASH, LED_COUNT, 0);
        push_cmd(FUNC_SPARE_LO, 5, 5);
        push_cmd(FUNC_SPARE_HI, 5, 5);
        push_cmd(FUNC_SCAN, 127, 0);
        push_cmd(FUNC_SCAN, 0, 5);
        push_cmd(FUNC_SCAN, 0, 1);
        push_cmd(FUNC_SCAN, 0, 6);
        push_cmd(FUNC_SCAN, 0, 7);
        push_cmd(FUNC_CLOSE, LED_COUNT - 1, 0);
        push_cmd(FUNC_SCAN, 0, 5);
        push_cmd(FUNC_TICK, 0, 0);
        push_cmd(FUNC_TICK, 0, 0);
        push_cmd(FUNC_SCAN, 0, 0);
        push_cmd(FUNC_TOGGLE, 60, 0);
        push_cmd(FUNC_SCAN, 0, 0);
        push_cmd(FUNC_TOGGLE, 60, 0);
        push_cmd(FUNC_SCAN, 0, 0);
        wait_quiet();

        // Fastest blink: phase flips on every tick.
        write_half_period(8'd1);
        push_random(150, 20);
        wait_quiet();

        // Slowest blink with many ticks to reach the top of the counter.
        send_idle = 1'b0;
        recv_idle = 1'b0;
        write_half_period(8'd255);
        push_random(300, 90);
        wait_quiet();

        // Lowering below the running count expires on the next tick.
        send_idle = 1'b1;
        recv_idle = 1'b1;
        write_half_period(8'd3);
        push_random(150, 20);
        wait_quiet();

        write_half_period(8'd2);
        push_random(150, 20);
        wait_quiet();

        recv_idle = 1'b0;
        write_half_period(HALF_W'($urandom_range(1, 20)));
        push_random(150, 30);
        wait_quiet();

        recv_idle = 1'b1;
        send_idle = 1'b0;
        write_half_period(HALF_W'($urandom_range(1, 255)));
        push_random(150, 30);
        wait_quiet();

        send_idle = 1'b1;
        write_half_period(8'd128);
        push_random(80, 40);
        wait_quiet();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_rows.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- led_matrix_blink_scanner.f -----
hdl/lmbs_pkg.sv
hdl/lmbs_flag_store.sv
hdl/led_matrix_blink_scanner.sv
hdl/lmbs_checker.sv
bench/led_matrix_blink_scanner_tb.sv
